/* sv/vpid_pkg.sv */
// Package: shared types, constants and sequencer states for the velocity PID block.
`default_nettype none
package vpid_pkg;
	localparam int W = 32;
	localparam int FB = 16;

	typedef enum logic [2:0] {
		REG_GAIN = 3'd0,
		REG_TI   = 3'd1,
		REG_TD   = 3'd2,
		REG_MIN  = 3'd3,
		REG_MAX  = 3'd4,
		REG_ALPHA = 3'd5,
		REG_BETA = 3'd6,
		REG_GAMMA = 3'd7
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_EN, S_TF, S_EP, S_ED, S_FN1, S_FN2, S_FDIV, S_FWAIT,
		S_PD, S_IMUL, S_IDIV, S_IWAIT, S_D2, S_DMUL, S_DDIV, S_DWAIT,
		S_SUM, S_KP, S_OUT, S_HOLD
	} state_t;

	// saturate a 66-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		if (x > 66'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -66'sh0_8000_0000) return 32'sh8000_0000;
		return x[31:0];
	endfunction
endpackage
`default_nettype wire

/* sv/vpid_div.sv */
// Radix-2 restoring divider, signed dividend, positive divisor, quotient truncated toward zero.
`default_nettype none
module vpid_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [65:0] dividend,
	input  wire logic        [32:0] divisor,
	output logic                    busy,
	output logic signed [65:0]      quotient
);
	import vpid_pkg::*;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [32:0] den_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;
	logic [63:0] mag;

	assign mag = dividend[65] ? 64'(-dividend) : dividend[63:0];
	assign trial = {rem_q, quo_q[63]} - {32'd0, den_q};
	assign busy = (cnt_q != 7'd0);
	assign quotient = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag;
			den_q <= divisor;
			neg_q <= dividend[65];
		end else if (busy) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

/* sv/velocity_pid_filtered_derivative.sv */
// Velocity-form PID controller with filtered derivative, sequenced over one shared datapath.
// Usage: write registers on cfg_we/cfg_index/cfg_data while idle. Each input transaction on
// s_axis carries step_time, setpoint, measured and actuator_now (Q16.16). One result
// transaction on m_axis returns drive and step_zeroed in tuser. s_axis_tready is high only
// when the sequencer is idle. Each of the three divisions (filter, integral, derivative) runs
// on one shared 64-step restoring divider; every multiply step uses one shared 33x35
// multiplier. A disabled integral term skips its division, a disabled derivative term its
// multiply and division, and a zero timestep skips both terms.
// The result sits in an output register until m_axis_tready; the next input is then taken
// in the cycle after delivery. Reset clears state, registers to their reset values and
// drops m_axis_tvalid. A stalled receiver holds the block.
`default_nettype none
module velocity_pid_filtered_derivative (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// step_time[30:0], setpoint[62:31], measured[94:63], actuator_now[126:95]
	input  wire logic [127:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// drive[31:0]
	output logic [31:0]      m_axis_tdata,
	// step_zeroed
	output logic             m_axis_tuser
);
	import vpid_pkg::*;

	logic signed [31:0] gain_q, min_q, max_q;
	logic [30:0] ti_q, td_q;
	logic [16:0] alpha_q, beta_q, gamma_q;
	logic signed [31:0] lpe_q, f1_q, f2_q;
	// edf2 before the shift (copy taken at PD)
	logic signed [31:0] f2_old_q;
	logic [30:0] ts_q;
	logic signed [31:0] r_q, y_q, u_q;
	logic signed [31:0] en_q, tf_q, epn_q, edn_q, edf0_q, it_q, dt_q, s_q, pd_q, d2_q;
	logic signed [65:0] acc_q;
	logic zero_q;
	state_t st_q, st_d;

	// shared multiplier
	logic signed [32:0] ma;
	logic signed [34:0] mb;
	logic signed [65:0] prod, prod_sh;
	logic div_start, div_busy;
	logic signed [65:0] div_num, div_q;
	logic [32:0] div_den;

	assign prod = 66'(ma) * 66'(mb);
	assign prod_sh = prod >>> FB;

	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			S_TF:  begin ma = {2'b0, td_q}; mb = {18'b0, alpha_q}; end
			S_EP:  begin ma = {r_q[31], r_q}; mb = {18'b0, beta_q}; end
			S_ED:  begin ma = {r_q[31], r_q}; mb = {18'b0, gamma_q}; end
			S_FN1: begin ma = {f1_q[31], f1_q}; mb = {{3{tf_q[31]}}, tf_q}; end
			S_FN2: begin ma = {edn_q[31], edn_q}; mb = {4'b0, ts_q}; end
			S_IMUL: begin ma = {en_q[31], en_q}; mb = {4'b0, ts_q}; end
			S_DMUL: begin ma = {d2_q[31], d2_q}; mb = {4'b0, td_q}; end
			S_KP:  begin ma = {s_q[31], s_q}; mb = {{3{gain_q[31]}}, gain_q}; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	vpid_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .busy(div_busy), .quotient(div_q)
	);

	always_comb begin
		div_start = 1'b0;
		div_num = acc_q;
		div_den = '0;
		case (st_q)
			S_FDIV: begin
				div_start = 1'b1;
				div_den = 33'({2'b0, ts_q}) + 33'($unsigned(tf_q));
			end
			S_IDIV: begin div_start = 1'b1; div_den = {2'b0, ti_q}; end
			S_DDIV: begin div_start = 1'b1; div_den = {2'b0, ts_q}; end
			default: div_start = 1'b0;
		endcase
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE: if (s_axis_tvalid) st_d = S_EN;
			S_EN:   st_d = S_TF;
			S_TF:   st_d = S_EP;
			S_EP:   st_d = S_ED;
			S_ED:   st_d = S_FN1;
			S_FN1:  st_d = S_FN2;
			S_FN2:  st_d = (ts_q == '0 && tf_q == '0) ? S_PD : S_FDIV;
			S_FDIV: st_d = S_FWAIT;
			S_FWAIT: if (!div_busy) st_d = S_PD;
			S_PD:   st_d = (ts_q == '0) ? S_OUT : S_IMUL;
			S_IMUL: st_d = (ti_q == '0) ? S_D2 : S_IDIV;
			S_IDIV: st_d = S_IWAIT;
			S_IWAIT: if (!div_busy) st_d = S_D2;
			S_D2:   st_d = (td_q == '0) ? S_SUM : S_DMUL;
			S_DMUL: st_d = S_DDIV;
			S_DDIV: st_d = S_DWAIT;
			S_DWAIT: if (!div_busy) st_d = S_SUM;
			S_SUM:  st_d = S_KP;
			S_KP:   st_d = S_OUT;
			S_OUT:  st_d = S_HOLD;
			S_HOLD: if (m_axis_tready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (st_q == S_IDLE);
		m_axis_tvalid = (st_q == S_HOLD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			gain_q <= 32'sd65536;
			ti_q <= '0;
			td_q <= '0;
			min_q <= 32'sh8000_0000;
			max_q <= 32'sh7FFF_FFFF;
			alpha_q <= 17'd6554;
			beta_q <= 17'd65536;
			gamma_q <= '0;
			lpe_q <= '0;
			f1_q <= '0;
			f2_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_GAIN:  gain_q <= cfg_data;
					REG_TI:    ti_q <= cfg_data[30:0];
					REG_TD:    td_q <= cfg_data[30:0];
					REG_MIN:   min_q <= cfg_data;
					REG_MAX:   max_q <= cfg_data;
					REG_ALPHA: alpha_q <= cfg_data[16:0];
					REG_BETA:  beta_q <= cfg_data[16:0];
					REG_GAMMA: gamma_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (st_q == S_PD) begin
				lpe_q <= epn_q;
				f2_q <= f1_q;
				f1_q <= edf0_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (s_axis_tvalid) begin
				ts_q <= s_axis_tdata[30:0];
				r_q <= s_axis_tdata[62:31];
				y_q <= s_axis_tdata[94:63];
				u_q <= s_axis_tdata[126:95];
				zero_q <= 1'b0;
				it_q <= '0;
				dt_q <= '0;
			end
			S_EN:  en_q <= sat32(66'(r_q) - 66'(y_q));
			S_TF:  tf_q <= sat32(prod_sh);
			S_EP:  epn_q <= sat32(prod_sh - 66'(y_q));
			S_ED:  edn_q <= sat32(prod_sh - 66'(y_q));
			S_FN1: acc_q <= prod;
			S_FN2: begin
				acc_q <= acc_q + prod;
				edf0_q <= f1_q;
			end
			S_FWAIT: if (!div_busy) edf0_q <= sat32(div_q);
			S_PD: begin
				pd_q <= sat32(66'(epn_q) - 66'(lpe_q));
				if (ts_q == '0) zero_q <= 1'b1;
			end
			S_IMUL: acc_q <= prod;
			S_IWAIT: if (!div_busy) it_q <= sat32(div_q);
			// state already shifted: f2 holds the old edf1, f2_old the old edf2
			S_D2: d2_q <= sat32(66'(edf0_q) - 66'(f2_q) * 66'sd2 + 66'(f2_old_q));
			S_DMUL: acc_q <= prod;
			S_DWAIT: if (!div_busy) dt_q <= sat32(div_q);
			S_SUM: s_q <= sat32(66'(pd_q) + 66'(it_q) + 66'(dt_q));
			S_KP: begin
				if (prod_sh > 66'sh0_7FFF_FFFF || prod_sh < -66'sh0_8000_0000) begin
					zero_q <= 1'b1;
					acc_q <= '0;
				end else begin
					acc_q <= prod_sh;
				end
			end
			S_OUT: begin
				logic signed [65:0] v;
				v = 66'(u_q) + ((zero_q) ? 66'sd0 : acc_q);
				if (v > 66'(max_q)) m_axis_tdata <= max_q;
				else if (v < 66'(min_q)) m_axis_tdata <= min_q;
				else m_axis_tdata <= v[31:0];
				m_axis_tuser <= zero_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == S_PD) f2_old_q <= f2_q;
	end
endmodule
`default_nettype wire
